### sv/rfcm_pkg.sv
package rfcm_pkg;

  localparam int unsigned BYTE_W       = 8;
  localparam int unsigned WORD_W       = 16;
  localparam int unsigned FRAME_LENGTH = 10;
  localparam int unsigned FRAME_STORE  = FRAME_LENGTH - 1;
  localparam int unsigned POS_W        = $clog2(FRAME_LENGTH);
  localparam int unsigned MAX_DEVICES  = 8;
  localparam int unsigned DEV_IDX_W    = $clog2(MAX_DEVICES);
  localparam int unsigned DEV_COUNT_W  = 4;
  localparam int unsigned ADDR_TABLE_W = MAX_DEVICES * BYTE_W;
  localparam int unsigned CFG_INDEX_W  = 2;
  localparam int unsigned CFG_DATA_W   = 64;

  localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_LENGTH - 1);

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_DEVICE_COUNT = 2'd0,
    CFG_ADDR_TABLE   = 2'd1
  } cfg_reg_t;

  // Outcome of the checksum compare against the address table
  typedef struct packed {
    logic                 hit;
    logic [DEV_IDX_W-1:0] idx;
  } match_t;

endpackage

### sv/rfcm_if.sv
interface rfcm_rx_if import rfcm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;
  logic              frame_start;

  modport source (output valid, output rx_byte, output frame_start, input ready);
  modport sink   (input valid, input rx_byte, input frame_start, output ready);
endinterface

interface rfcm_res_if import rfcm_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 matched;
  logic [DEV_IDX_W-1:0] device_index;
  logic [WORD_W-1:0]    measured_value;
  logic [WORD_W-1:0]    setpoint_value;
  logic [BYTE_W-1:0]    output_value;
  logic [BYTE_W-1:0]    alarm_status;
  logic [WORD_W-1:0]    parameter_value;

  modport source (output valid, output matched, output device_index,
                  output measured_value, output setpoint_value, output output_value,
                  output alarm_status, output parameter_value, input ready);
  modport sink   (input valid, input matched, input device_index,
                  input measured_value, input setpoint_value, input output_value,
                  input alarm_status, input parameter_value, output ready);
endinterface

interface rfcm_cfg_if import rfcm_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] reg_index;
  logic [CFG_DATA_W-1:0]  data;

  modport source (output valid, output reg_index, output data, input ready);
  modport sink   (input valid, input reg_index, input data, output ready);
endinterface

### sv/response_frame_checksum_matcher_core.sv
// Response frame checksum matcher.
// rx channel: one received byte per transaction; frame_start marks byte 0 of a
// frame and resynchronizes the byte counter. Ten bytes make a frame: measured
// value, setpoint, output byte, alarm byte, parameter (16-bit fields little
// endian) and a 16-bit checksum. The checksum must equal the field sum plus the
// address of one of the first device_count table entries (mod 2^16).
// res channel: one transaction per completed frame carrying the match flag,
// lowest matching device index and the decoded fields (all zero on no match).
// cfg channel: register writes, always ready; index 0 = device_count (values
// above 8 act as 8), index 1 = packed 8-bit device address table.
// Throughput: one byte per cycle. After the tenth byte's transaction the result
// goes through the sum register, then the compare into the output register.
// rx.ready drops only when both pipeline registers hold a frame and res is
// stalled; bytes 0..8 then wait too.
// Reset (rst, synchronous) clears the byte counter, the pipeline valids and
// the configuration (zero devices, zero table).
module response_frame_checksum_matcher_core import rfcm_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  rfcm_cfg_if.sink  cfg,
  rfcm_rx_if.sink   rx,
  rfcm_res_if.source res
);

  // configuration
  logic [DEV_COUNT_W-1:0]  dev_count;
  logic [ADDR_TABLE_W-1:0] addr_table;
  logic [DEV_COUNT_W-1:0]  dev_count_eff;

  // frame assembly
  logic [POS_W-1:0]  byte_position;
  logic [POS_W-1:0]  pos_eff;
  logic [BYTE_W-1:0] frame_bytes [FRAME_STORE];
  logic              rx_fire;
  logic              last_byte;

  // sum stage
  logic              s1_valid;
  logic [WORD_W-1:0] s1_sum;
  logic [WORD_W-1:0] s1_rx;
  logic [WORD_W-1:0] s1_pv;
  logic [WORD_W-1:0] s1_sv;
  logic [BYTE_W-1:0] s1_ov;
  logic [BYTE_W-1:0] s1_al;
  logic [WORD_W-1:0] s1_pr;
  logic [WORD_W-1:0] pv_next;
  logic [WORD_W-1:0] sv_next;
  logic [WORD_W-1:0] pr_next;
  logic [WORD_W-1:0] sum_next;

  // output register
  logic                 out_valid;
  logic                 out_matched;
  logic [DEV_IDX_W-1:0] out_idx;
  logic [WORD_W-1:0]    out_pv;
  logic [WORD_W-1:0]    out_sv;
  logic [BYTE_W-1:0]    out_ov;
  logic [BYTE_W-1:0]    out_al;
  logic [WORD_W-1:0]    out_pr;
  logic                 out_load;
  logic                 s1_free;
  match_t               match;

  // ---------------- configuration port ----------------
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      dev_count  <= '0;
      addr_table <= '0;
    end else if (cfg.valid) begin
      case (cfg.reg_index)
        CFG_DEVICE_COUNT: dev_count  <= cfg.data[DEV_COUNT_W-1:0];
        CFG_ADDR_TABLE:   addr_table <= cfg.data[ADDR_TABLE_W-1:0];
        default: ;
      endcase
    end
  end

  assign dev_count_eff = (dev_count > DEV_COUNT_W'(MAX_DEVICES)) ?
                         DEV_COUNT_W'(MAX_DEVICES) : dev_count;

  // ---------------- handshake ----------------
  assign out_load = !out_valid || res.ready;
  assign s1_free  = !s1_valid || out_load;
  assign rx.ready = s1_free;
  assign rx_fire  = rx.valid && rx.ready;

  // ---------------- frame assembly ----------------
  assign pos_eff   = rx.frame_start ? '0 : byte_position;
  assign last_byte = (pos_eff == LAST_POS);

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
    end else if (rx_fire) begin
      byte_position <= last_byte ? '0 : POS_W'(pos_eff + 1'b1);
    end
  end

  // byte store, no reset: every entry is written before the frame end reads it
  always_ff @(posedge clk) begin
    if (rx_fire && !last_byte) begin
      frame_bytes[pos_eff] <= rx.rx_byte;
    end
  end

  // field decode and 16-bit field sum on the tenth byte
  assign pv_next  = {frame_bytes[1], frame_bytes[0]};
  assign sv_next  = {frame_bytes[3], frame_bytes[2]};
  assign pr_next  = {frame_bytes[7], frame_bytes[6]};
  assign sum_next = WORD_W'(pv_next + sv_next + {frame_bytes[5], BYTE_W'(0)}
                            + WORD_W'(frame_bytes[4]) + pr_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_free) begin
      s1_valid <= rx_fire && last_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rx_fire && last_byte) begin
      s1_sum <= sum_next;
      s1_rx  <= {rx.rx_byte, frame_bytes[8]};
      s1_pv  <= pv_next;
      s1_sv  <= sv_next;
      s1_ov  <= frame_bytes[4];
      s1_al  <= frame_bytes[5];
      s1_pr  <= pr_next;
    end
  end

  // ---------------- checksum compare ----------------
  rfcm_match u_match (
    .sum        (s1_sum),
    .rx_sum     (s1_rx),
    .addr_table (addr_table),
    .dev_count  (dev_count_eff),
    .match      (match)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= s1_valid;
    end
  end

  // fields are zeroed when no device matched
  always_ff @(posedge clk) begin
    if (out_load && s1_valid) begin
      out_matched <= match.hit;
      out_idx     <= match.hit ? match.idx : '0;
      out_pv      <= match.hit ? s1_pv : '0;
      out_sv      <= match.hit ? s1_sv : '0;
      out_ov      <= match.hit ? s1_ov : '0;
      out_al      <= match.hit ? s1_al : '0;
      out_pr      <= match.hit ? s1_pr : '0;
    end
  end

  assign res.valid           = out_valid;
  assign res.matched         = out_matched;
  assign res.device_index    = out_idx;
  assign res.measured_value  = out_pv;
  assign res.setpoint_value  = out_sv;
  assign res.output_value    = out_ov;
  assign res.alarm_status    = out_al;
  assign res.parameter_value = out_pr;

  // ---------------- assertions ----------------
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    byte_position <= LAST_POS)
    else $error("byte counter past frame end");

  a_frame_to_s1: assert property (@(posedge clk) disable iff (rst)
    rx_fire && last_byte |=> s1_valid)
    else $error("completed frame lost before sum stage");

  a_nomatch_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_matched |-> out_idx == '0 && out_pv == '0 && out_sv == '0 &&
                                  out_ov == '0 && out_al == '0 && out_pr == '0)
    else $error("unmatched frame carries nonzero fields");

  a_idx_enabled: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_matched |-> DEV_COUNT_W'(out_idx) < dev_count_eff)
    else $error("match reported on a disabled device");

endmodule

### sv/rfcm_match.sv
module rfcm_match import rfcm_pkg::*; (
  input  logic [WORD_W-1:0]       sum,
  input  logic [WORD_W-1:0]       rx_sum,
  input  logic [ADDR_TABLE_W-1:0] addr_table,
  input  logic [DEV_COUNT_W-1:0]  dev_count,
  output match_t                  match
);

  logic [MAX_DEVICES-1:0] hits;

  // per-device compare, gated by the number of enabled devices
  always_comb begin
    for (int i = 0; i < MAX_DEVICES; i++) begin
      hits[i] = (DEV_COUNT_W'(i) < dev_count) &&
                (rx_sum == WORD_W'(sum + WORD_W'(addr_table[i*BYTE_W +: BYTE_W])));
    end
  end

  // lowest index wins
  always_comb begin
    match.hit = |hits;
    match.idx = '0;
    for (int i = MAX_DEVICES - 1; i >= 0; i--) begin
      if (hits[i]) begin
        match.idx = DEV_IDX_W'(i);
      end
    end
  end

endmodule

### tb/tb_response_frame_checksum_matcher_core.sv
`timescale 1ns / 1ps

module tb_response_frame_checksum_matcher_core import rfcm_pkg::*; ();

  // Run shape
  localparam int unsigned IDLE_PCT       = 9;     // per-cycle idle odds, each side
  localparam int unsigned PHASE_ITEMS    = 95;    // rx bytes per random phase
  localparam int unsigned NUM_PHASES     = 7;
  localparam int unsigned SETTLE_CYCLES  = 6;     // pipeline is two deep
  localparam int unsigned WATCHDOG_LIMIT = 2000;  // cycles with no transaction at all
  localparam int unsigned MAX_REPORTS    = 100;

  // One decoded response frame, as the res channel carries it
  typedef struct packed {
    logic                 matched;
    logic [DEV_IDX_W-1:0] device_index;
    logic [WORD_W-1:0]    measured;
    logic [WORD_W-1:0]    setpoint;
    logic [BYTE_W-1:0]    out_level;
    logic [BYTE_W-1:0]    alarm;
    logic [WORD_W-1:0]    param;
  } frame_result_t;

  localparam frame_result_t NO_MATCH = '0;
  // all-zero frame whose checksum equals the address of the last table entry
  localparam frame_result_t HIT_LAST = '{1'b1, 3'd7, 16'h0000, 16'h0000, 8'h00, 8'h00,
                                         16'h0000};

  // Directed stimulus row: either a register setting (both registers) or one rx byte.
  // Pinned rows carry a hand-written expectation for the frame they complete.
  typedef struct {
    bit                     is_cfg;
    logic [DEV_COUNT_W-1:0] cnt;
    logic [ADDR_TABLE_W-1:0] tab;
    logic [BYTE_W-1:0]      rx_b;
    logic                   start;
    bit                     pinned;
    frame_result_t          want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst;

  rfcm_cfg_if cfg_ch ();
  rfcm_rx_if  rx_ch ();
  rfcm_res_if res_ch ();

  response_frame_checksum_matcher_core dut (
    .clk (clk),
    .rst (rst),
    .cfg (cfg_ch),
    .rx  (rx_ch),
    .res (res_ch)
  );

  // 2 ns period
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Predictor state: own copy of the registers and the frame being assembled
  logic [DEV_COUNT_W-1:0]  dev_cnt;
  logic [ADDR_TABLE_W-1:0] addr_tab;
  logic [POS_W-1:0]        frame_pos;
  logic [BYTE_W-1:0]       frame_buf [FRAME_STORE];

  frame_result_t pending_frames [$];   // decoded frames still owed by the DUT
  dir_row_t      dir_rows [$];

  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles   = 0;
  int unsigned rx_count       = 0;

  // Driven by the sender together with valid; read by the monitor on acceptance
  bit            pin_now = 1'b0;
  frame_result_t pin_want = '0;
  // No idling on either side while set
  bit            steady = 1'b0;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("[%0t] mismatch: %s got 0x%0h expected 0x%0h", $time, what, got, want);
  endtask

  // 16-bit additive sum over the frame fields; alarm byte weighs 256
  function automatic logic [WORD_W-1:0] frame_sum(input logic [WORD_W-1:0] pv, sv,
                                                 input logic [BYTE_W-1:0] ov, al,
                                                 input logic [WORD_W-1:0] pr);
    return 16'(pv + sv + {al, 8'h00} + 16'(ov) + pr);
  endfunction

  // Takes one accepted rx byte; returns 1 and the decoded frame on the tenth byte
  function automatic bit absorb_byte(input logic [BYTE_W-1:0] b, input logic s,
                                     output frame_result_t r);
    logic [WORD_W-1:0] pv, sv, pr, rxc, sum;
    logic [BYTE_W-1:0] ov, al;
    int unsigned       n;
    r = NO_MATCH;
    if (s) frame_pos = '0;
    if (frame_pos < FRAME_STORE) begin
      frame_buf[frame_pos] = b;
      frame_pos = frame_pos + 1'b1;
      return 1'b0;
    end
    frame_pos = '0;
    pv  = {frame_buf[1], frame_buf[0]};
    sv  = {frame_buf[3], frame_buf[2]};
    ov  = frame_buf[4];
    al  = frame_buf[5];
    pr  = {frame_buf[7], frame_buf[6]};
    rxc = {b, frame_buf[8]};
    sum = frame_sum(pv, sv, ov, al, pr);
    // counts above the table size clamp to the full table
    n = (dev_cnt > MAX_DEVICES) ? MAX_DEVICES : dev_cnt;
    for (int i = 0; i < n; i++) begin
      if (rxc == 16'(sum + addr_tab[8*i +: 8])) begin
        r = '{1'b1, DEV_IDX_W'(i), pv, sv, ov, al, pr};
        return 1'b1;
      end
    end
    return 1'b1;
  endfunction

  function automatic dir_row_t rx_row(input logic [BYTE_W-1:0] b, input logic s,
                                      input bit pin, input frame_result_t want);
    dir_row_t row;
    row        = '{default: '0};
    row.rx_b   = b;
    row.start  = s;
    row.pinned = pin;
    row.want   = want;
    return row;
  endfunction

  function automatic dir_row_t cfg_row(input logic [DEV_COUNT_W-1:0] cnt,
                                       input logic [ADDR_TABLE_W-1:0] tab);
    dir_row_t row;
    row        = '{default: '0};
    row.is_cfg = 1'b1;
    row.cnt    = cnt;
    row.tab    = tab;
    return row;
  endfunction

  // All of these start and end at a falling edge.

  // Wait for every owed frame, then wait out SETTLE_CYCLES so the pipeline is empty
  task automatic settle();
    while (pending_frames.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Both registers back to back; valid stays high across the pair
  task automatic program_regs(input logic [DEV_COUNT_W-1:0] cnt,
                              input logic [ADDR_TABLE_W-1:0] tab);
    // the sender holds off while the DUT drains
    rx_ch.valid <= 1'b0;
    settle();
    cfg_ch.valid     <= 1'b1;
    cfg_ch.reg_index <= CFG_DEVICE_COUNT;
    cfg_ch.data      <= CFG_DATA_W'(cnt);
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.reg_index <= CFG_ADDR_TABLE;
    cfg_ch.data      <= tab;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic s, input bit pin,
                           input frame_result_t want);
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      rx_ch.valid <= 1'b0;
      @(negedge clk);
    end
    rx_ch.valid       <= 1'b1;
    rx_ch.rx_byte     <= b;
    rx_ch.frame_start <= s;
    pin_now           <= pin;
    pin_want          <= want;
    do @(posedge clk); while (!rx_ch.ready);
    rx_count++;
    @(negedge clk);
  endtask

  function automatic logic [WORD_W-1:0] pick_word();
    case ($urandom_range(0, 7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // One response frame with random content. Most checksums are built to hit some
  // table entry (possibly one beyond the device count); a few frames are cut short
  // or sent without frame_start.
  task automatic send_frame();
    logic [BYTE_W-1:0] fb [FRAME_LENGTH];
    logic [WORD_W-1:0] pv, sv, pr, cks;
    logic [BYTE_W-1:0] ov, al;
    int unsigned       j, cut;
    bit                synced;
    pv = pick_word();
    sv = pick_word();
    pr = pick_word();
    ov = 8'($urandom);
    al = 8'($urandom);
    if ($urandom_range(0, 99) < 70) begin
      j   = $urandom_range(0, MAX_DEVICES - 1);
      cks = 16'(frame_sum(pv, sv, ov, al, pr) + addr_tab[8*j +: 8]);
    end else begin
      cks = 16'($urandom);
    end
    fb[0] = pv[7:0];  fb[1] = pv[15:8];
    fb[2] = sv[7:0];  fb[3] = sv[15:8];
    fb[4] = ov;       fb[5] = al;
    fb[6] = pr[7:0];  fb[7] = pr[15:8];
    fb[8] = cks[7:0]; fb[9] = cks[15:8];
    cut    = ($urandom_range(0, 99) < 8) ? $urandom_range(1, FRAME_LENGTH - 1) : FRAME_LENGTH;
    synced = ($urandom_range(0, 99) < 90);
    for (int k = 0; k < cut; k++)
      send_byte(fb[k], (k == 0) && synced, 1'b0, NO_MATCH);
  endtask

  // Result sink: random back-pressure except during the steady phase
  initial begin
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      res_ch.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // Monitor: register writes and rx bytes feed the predictor, results are checked
  // against the oldest owed frame. Sampled at the rising edge; inputs move at the
  // falling edge, so there is no race with the DUT.
  always @(posedge clk) begin
    frame_result_t got, want;
    bit            done;
    if (rst) begin
      dev_cnt   = '0;
      addr_tab  = '0;
      frame_pos = '0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.reg_index)
          CFG_DEVICE_COUNT: dev_cnt  = cfg_ch.data[DEV_COUNT_W-1:0];
          CFG_ADDR_TABLE:   addr_tab = cfg_ch.data;
          default: ;
        endcase
      end
      if (rx_ch.valid && rx_ch.ready) begin
        done = absorb_byte(rx_ch.rx_byte, rx_ch.frame_start, want);
        if (pin_now) begin
          if (!done) report_mismatch("pinned row completes no frame", 64'd0, 64'd1);
          want = pin_want;
        end
        if (done) pending_frames.push_back(want);
      end
      if (res_ch.valid && res_ch.ready) begin
        got = '{res_ch.matched, res_ch.device_index, res_ch.measured_value,
                res_ch.setpoint_value, res_ch.output_value, res_ch.alarm_status,
                res_ch.parameter_value};
        if (pending_frames.size() == 0) begin
          report_mismatch("result with no frame owed", 64'(got), 64'd0);
        end else begin
          want = pending_frames.pop_front();
          if (got.matched != want.matched)
            report_mismatch("matched", 64'(got.matched), 64'(want.matched));
          if (got.device_index != want.device_index)
            report_mismatch("device_index", 64'(got.device_index),
                            64'(want.device_index));
          if (got.measured != want.measured)
            report_mismatch("measured_value", 64'(got.measured), 64'(want.measured));
          if (got.setpoint != want.setpoint)
            report_mismatch("setpoint_value", 64'(got.setpoint), 64'(want.setpoint));
          if (got.out_level != want.out_level)
            report_mismatch("output_value", 64'(got.out_level), 64'(want.out_level));
          if (got.alarm != want.alarm)
            report_mismatch("alarm_status", 64'(got.alarm), 64'(want.alarm));
          if (got.param != want.param)
            report_mismatch("parameter_value", 64'(got.param), 64'(want.param));
        end
      end
    end
  end

  // Watchdog: too long without any transaction on any channel
  always @(posedge clk) begin
    if ((rx_ch.valid && rx_ch.ready) || (res_ch.valid && res_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[%0t] watchdog: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [DEV_COUNT_W-1:0]  cnt;
    logic [ADDR_TABLE_W-1:0] tab;
    int unsigned             phase_base;

    rst               = 1'b1;
    rx_ch.valid       = 1'b0;
    rx_ch.rx_byte     = '0;
    rx_ch.frame_start = 1'b0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.reg_index  = CFG_DEVICE_COUNT;
    cfg_ch.data       = '0;

    // Directed table.
    // Reset config has no devices: all-ones frame gives no match, fields zeroed.
    for (int k = 0; k < FRAME_LENGTH; k++)
      dir_rows.push_back(rx_row(8'hFF, k == 0, k == FRAME_LENGTH - 1, NO_MATCH));
    // Count above the table size acts as the full table; distinct addresses.
    dir_rows.push_back(cfg_row(4'hF, 64'h8007_0605_0403_0201));
    // Stray bytes with no frame_start, then a frame that resyncs on frame_start.
    // Zero fields with checksum 0x0080 can only hit entry 7.
    for (int k = 0; k < 3; k++)
      dir_rows.push_back(rx_row(8'h77, 1'b0, 1'b0, NO_MATCH));
    for (int k = 0; k < FRAME_LENGTH; k++)
      dir_rows.push_back(rx_row((k == 8) ? 8'h80 : 8'h00, k == 0, k == FRAME_LENGTH - 1,
                                HIT_LAST));

    repeat (5) @(negedge clk);
    rst <= 1'b0;

    foreach (dir_rows[k]) begin
      if (dir_rows[k].is_cfg)
        program_regs(dir_rows[k].cnt, dir_rows[k].tab);
      else
        send_byte(dir_rows[k].rx_b, dir_rows[k].start, dir_rows[k].pinned,
                  dir_rows[k].want);
    end

    // Random phases, each under its own register setting. program_regs drains
    // the DUT first, so every phase boundary is a full pause of the sender.
    for (int p = 0; p < NUM_PHASES; p++) begin
      tab = {$urandom, $urandom};
      case (p)
        0: cnt = 4'd0;
        1: cnt = 4'd8;
        2: begin
          cnt = 4'd15;
          tab = '1;
        end
        3: begin
          cnt = 4'd1;
          tab = '0;
        end
        4: cnt = 4'd5;
        5: begin
          // few distinct addresses: lowest matching index has to win
          cnt = 4'd12;
          for (int e = 0; e < MAX_DEVICES; e++) tab[8*e +: 8] = 8'($urandom_range(0, 2));
        end
        default: cnt = 4'd3;
      endcase
      program_regs(cnt, tab);
      steady <= (p == 2);
      phase_base = rx_count;
      while (rx_count - phase_base < PHASE_ITEMS) begin
        if ($urandom_range(0, 99) < 6)
          send_byte(8'($urandom), 1'($urandom_range(0, 1)), 1'b0, NO_MATCH);
        else
          send_frame();
      end
    end
    steady      <= 1'b0;
    rx_ch.valid <= 1'b0;

    settle();
    if (pending_frames.size() != 0)
      report_mismatch("frames never delivered", 64'd0, 64'(pending_frames.size()));
    if (mismatch_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

### response_frame_checksum_matcher_core.f
sv/rfcm_pkg.sv
sv/rfcm_if.sv
sv/rfcm_match.sv
sv/response_frame_checksum_matcher_core.sv
tb/tb_response_frame_checksum_matcher_core.sv
